// ===== src/ccv_pkg.sv =====
// ----------------------------------------------------------------------------
// ccv_pkg
// Shared types and constants for the streaming 2D cross-correlation block.
// ----------------------------------------------------------------------------
package ccv_pkg;

    localparam int VAL_W     = 16;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int SUM_W     = 40;
    localparam int POS_W     = 10;
    localparam int OUT_W     = 10;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int KDIM_W    = 2;
    localparam int IDX_W     = 4;
    localparam int ROWS_MAX  = 1024;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_COEF  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS  = 2'd3;

    typedef struct packed {
        logic             win_shift;
        logic             prod_load;
        logic             coef_we;
        logic [IDX_W-1:0] coef_idx;
    } t_mac_ctrl;

endpackage

// ===== src/ccv_line_store.sv =====
// ----------------------------------------------------------------------------
// ccv_line_store
// One-write one-read line memory with a registered read port.
// ----------------------------------------------------------------------------
module ccv_line_store #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/ccv_mac.sv =====
// ----------------------------------------------------------------------------
// ccv_mac
// Window registers, kernel coefficients and one registered product per tap.
// ----------------------------------------------------------------------------
module ccv_mac
    import ccv_pkg::*;
#(
    parameter int KERNEL_MAX = 3,
    parameter int KU         = 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_mac_ctrl                       i_ctrl,
    input  logic [KU-1:0][VAL_W-1:0]        i_column,
    input  logic [VAL_W-1:0]                i_coef_value,
    input  logic [KDIM_W-1:0]               i_kernel_rows,
    input  logic [KDIM_W-1:0]               i_kernel_cols,
    output logic [KU*KU-1:0][PROD_W-1:0]    o_prod
);

    // window: first index is row age, second is column age (0 = newest)
    logic [KU-1:0][KU-1:0][VAL_W-1:0]  r_win;
    logic [KU-1:0][KU-1:0][VAL_W-1:0]  r_coef;
    logic [KU*KU-1:0][PROD_W-1:0]      r_prod;
    logic [KU-1:0][KU-1:0][VAL_W-1:0]  csel;
    logic [KU-1:0][KU-1:0][VAL_W-1:0]  wsel;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.win_shift) begin
            for (int i = 0; i < KU; i++) begin
                r_win[i][0] <= i_column[i];
                for (int j = 1; j < KU; j++) begin
                    r_win[i][j] <= r_win[i][j-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (i_ctrl.coef_we) begin
            for (int m = 0; m < KU; m++) begin
                for (int n = 0; n < KU; n++) begin
                    if ({1'b0, i_ctrl.coef_idx} == (IDX_W+1)'(m * KERNEL_MAX + n)) begin
                        r_coef[m][n] <= i_coef_value;
                    end
                end
            end
        end
    end

    // tap at ages (i,j) uses coefficient (rows-1-i, cols-1-j);
    // taps outside the kernel are forced to zero on both operands
    always_comb begin
        csel = '0;
        wsel = '0;
        for (int i = 0; i < KU; i++) begin
            for (int j = 0; j < KU; j++) begin
                for (int m = 0; m < KU; m++) begin
                    for (int n = 0; n < KU; n++) begin
                        if ((3'(m + i + 1) == {1'b0, i_kernel_rows}) &&
                            (3'(n + j + 1) == {1'b0, i_kernel_cols})) begin
                            csel[i][j] = r_coef[m][n];
                            wsel[i][j] = r_win[i][j];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.prod_load) begin
            for (int i = 0; i < KU; i++) begin
                for (int j = 0; j < KU; j++) begin
                    r_prod[i*KU+j] <= $signed(wsel[i][j]) * $signed(csel[i][j]);
                end
            end
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== src/cross_correlation_2d_valid_top.sv =====
// ----------------------------------------------------------------------------
// cross_correlation_2d_valid_top
// Streaming valid-mode 2D cross-correlation over a raster pixel stream.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------------
//   in      | sink      | i_valid / o_stall     | i_cmd, i_value, i_coef_index
//   out     | source    | o_valid / i_stall     | o_out_row, o_out_col, o_sum, o_last
//   cfg     | sink      | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One beat per cycle in and out unless a stall holds the flow.
// The line memory read is issued at accept, the window shifts, all taps
// multiply in parallel, then one adder tree feeds the output register.
// Stages compress bubbles; o_stall rises only when every stage is full.
// Synchronous reset clears control and coefficients, not data; no clearing pass.
// ----------------------------------------------------------------------------
module cross_correlation_2d_valid_top
    import ccv_pkg::*;
#(
    parameter int KERNEL_MAX = 3,
    parameter int MAX_COLS   = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_cmd,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic [IDX_W-1:0]        i_coef_index,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [OUT_W-1:0]        o_out_row,
    output logic [OUT_W-1:0]        o_out_col,
    output logic signed [SUM_W-1:0] o_sum,
    output logic                    o_last,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    localparam int KU       = (KERNEL_MAX < 3) ? KERNEL_MAX : 3;
    localparam int LB_ROWS  = (KU > 1) ? KU - 1 : 1;
    localparam int LB_W     = LB_ROWS * VAL_W;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ICOL_W   = $clog2(MAX_COLS + 1);
    localparam int ICMP_W   = (ICOL_W > CFG_W) ? ICOL_W : CFG_W;
    localparam int ICOL_RST = (MAX_COLS < 640) ? MAX_COLS : 640;

    // configuration
    logic [KDIM_W-1:0] r_kr, r_kc;
    logic [ICOL_W-1:0] r_icols;
    logic [CFG_W-1:0]  r_irows;
    logic              cfg_we;
    logic [KDIM_W-1:0] cfg_kdim;
    logic [ICOL_W-1:0] cfg_icols;
    logic [CFG_W-1:0]  cfg_irows;

    // position
    logic [POS_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic              pos_bad;
    logic [POS_W-1:0]  cur_row;
    logic [COL_W-1:0]  cur_col;
    logic [CFG_W-1:0]  row_p1;
    logic [ICOL_W-1:0] col_p1;
    logic              cur_prod, cur_last;
    logic [POS_W-1:0]  cur_r0;
    logic [COL_W-1:0]  cur_c0;

    // handshake
    logic rdy1, rdy2, rdy3, rdy_o;
    logic in_acc, in_pix;

    // stage 1
    logic               r1_v, r1_cmd, r1_prod, r1_last, r1_fwd;
    logic [VAL_W-1:0]   r1_value;
    logic [IDX_W-1:0]   r1_idx;
    logic [COL_W-1:0]   r1_col;
    logic [POS_W-1:0]   r1_r0;
    logic [COL_W-1:0]   r1_c0;
    logic [LB_W-1:0]    r1_fwd_data;

    // stage 2
    logic               r2_v, r2_cmd, r2_prod, r2_last;
    logic [VAL_W-1:0]   r2_value;
    logic [IDX_W-1:0]   r2_idx;
    logic [POS_W-1:0]   r2_r0;
    logic [COL_W-1:0]   r2_c0;

    // stage 3
    logic               r3_v, r3_last;
    logic [POS_W-1:0]   r3_r0;
    logic [COL_W-1:0]   r3_c0;

    // output
    logic               r_ov, r_olast;
    logic [OUT_W-1:0]   r_orow, r_ocol;
    logic [SUM_W-1:0]   r_osum;

    // line store and datapath
    logic [LB_W-1:0]                  lb_rd_data;
    logic                             lb_wr_en;
    logic [LB_ROWS-1:0][VAL_W-1:0]    col_word, new_word;
    logic [KU-1:0][VAL_W-1:0]         column;
    logic [KU*KU-1:0][PROD_W-1:0]     prod;
    logic [SUM_W-1:0]                 sum;
    t_mac_ctrl                        mac_ctrl;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_comb begin
        if (i_cfg_data[KDIM_W-1:0] == '0) begin
            cfg_kdim = KDIM_W'(1);
        end else if (i_cfg_data[KDIM_W-1:0] > KDIM_W'(KU)) begin
            cfg_kdim = KDIM_W'(KU);
        end else begin
            cfg_kdim = i_cfg_data[KDIM_W-1:0];
        end
        if (i_cfg_data == '0) begin
            cfg_icols = ICOL_W'(1);
        end else if (ICMP_W'(i_cfg_data) > ICMP_W'(MAX_COLS)) begin
            cfg_icols = ICOL_W'(MAX_COLS);
        end else begin
            cfg_icols = ICOL_W'(i_cfg_data);
        end
        if (i_cfg_data == '0) begin
            cfg_irows = CFG_W'(1);
        end else if (i_cfg_data > CFG_W'(ROWS_MAX)) begin
            cfg_irows = CFG_W'(ROWS_MAX);
        end else begin
            cfg_irows = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kr    <= KDIM_W'(KU);
            r_kc    <= KDIM_W'(KU);
            r_icols <= ICOL_W'(ICOL_RST);
            r_irows <= CFG_W'(480);
        end else if (cfg_we) begin
            case (i_cfg_index)
                REG_KERNEL_ROWS: r_kr    <= cfg_kdim;
                REG_KERNEL_COLS: r_kc    <= cfg_kdim;
                REG_IMAGE_COLS:  r_icols <= cfg_icols;
                REG_IMAGE_ROWS:  r_irows <= cfg_irows;
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign rdy_o   = !r_ov || !i_stall;
    assign rdy3    = !r3_v || rdy_o;
    assign rdy2    = !r2_v || rdy3;
    assign rdy1    = !r1_v || rdy2;
    assign o_stall = !rdy1;
    assign in_acc  = i_valid && rdy1;
    assign in_pix  = in_acc && (i_cmd == CMD_PIXEL);

    // ---------------- position ----------------
    always_comb begin
        pos_bad  = ({1'b0, r_row} >= r_irows) || (ICOL_W'(r_col) >= r_icols);
        cur_row  = pos_bad ? '0 : r_row;
        cur_col  = pos_bad ? '0 : r_col;
        row_p1   = {1'b0, cur_row} + CFG_W'(1);
        col_p1   = ICOL_W'(cur_col) + ICOL_W'(1);
        cur_prod = (row_p1 >= CFG_W'(r_kr)) && (col_p1 >= ICOL_W'(r_kc));
        cur_last = (row_p1 == r_irows) && (col_p1 == r_icols);
        cur_r0   = cur_row - POS_W'(r_kr) + POS_W'(1);
        cur_c0   = cur_col - COL_W'(r_kc) + COL_W'(1);
        n_row    = r_row;
        n_col    = r_col;
        if (cfg_we) begin
            n_row = '0;
            n_col = '0;
        end else if (in_pix) begin
            if (col_p1 >= r_icols) begin
                n_col = '0;
                n_row = (row_p1 >= r_irows) ? '0 : row_p1[POS_W-1:0];
            end else begin
                n_col = col_p1[COL_W-1:0];
                n_row = cur_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // ---------------- line store ----------------
    assign lb_wr_en = rdy2 && r1_v && (r1_cmd == CMD_PIXEL);
    assign col_word = r1_fwd ? r1_fwd_data : lb_rd_data;

    always_comb begin
        new_word[0] = r1_value;
        for (int k = 1; k < LB_ROWS; k++) begin
            new_word[k] = col_word[k-1];
        end
        column[0] = r1_value;
        for (int i = 1; i < KU; i++) begin
            column[i] = col_word[i-1];
        end
    end

    ccv_line_store #(
        .DEPTH (MAX_COLS),
        .WIDTH (LB_W)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (in_pix),
        .i_rd_addr (cur_col),
        .o_rd_data (lb_rd_data),
        .i_wr_en   (lb_wr_en),
        .i_wr_addr (r1_col),
        .i_wr_data (new_word)
    );

    // ---------------- stage 1 ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (rdy1) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r1_cmd      <= i_cmd;
            r1_value    <= i_value;
            r1_idx      <= i_coef_index;
            r1_col      <= cur_col;
            r1_prod     <= cur_prod;
            r1_last     <= cur_last;
            r1_r0       <= cur_r0;
            r1_c0       <= cur_c0;
            r1_fwd      <= lb_wr_en && (r1_col == cur_col);
            r1_fwd_data <= new_word;
        end
    end

    // ---------------- stage 2 (window) ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (rdy2) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r2_cmd   <= r1_cmd;
            r2_value <= r1_value;
            r2_idx   <= r1_idx;
            r2_prod  <= r1_prod;
            r2_last  <= r1_last;
            r2_r0    <= r1_r0;
            r2_c0    <= r1_c0;
        end
    end

    always_comb begin
        mac_ctrl.win_shift = lb_wr_en;
        mac_ctrl.prod_load = rdy3 && r2_v && (r2_cmd == CMD_PIXEL);
        mac_ctrl.coef_we   = rdy3 && r2_v && (r2_cmd == CMD_COEF);
        mac_ctrl.coef_idx  = r2_idx;
    end

    ccv_mac #(
        .KERNEL_MAX (KERNEL_MAX),
        .KU         (KU)
    ) u_mac (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (mac_ctrl),
        .i_column      (column),
        .i_coef_value  (r2_value),
        .i_kernel_rows (r_kr),
        .i_kernel_cols (r_kc),
        .o_prod        (prod)
    );

    // ---------------- stage 3 (products) ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (rdy3) begin
            r3_v <= r2_v && (r2_cmd == CMD_PIXEL) && r2_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r3_last <= r2_last;
            r3_r0   <= r2_r0;
            r3_c0   <= r2_c0;
        end
    end

    always_comb begin
        sum = '0;
        for (int k = 0; k < KU * KU; k++) begin
            sum = sum + {{(SUM_W-PROD_W){prod[k][PROD_W-1]}}, prod[k]};
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (rdy_o) begin
            r_ov <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_o) begin
            r_osum  <= sum;
            r_orow  <= OUT_W'(r3_r0);
            r_ocol  <= OUT_W'(r3_c0);
            r_olast <= r3_last;
        end
    end

    assign o_valid   = r_ov;
    assign o_sum     = r_osum;
    assign o_out_row = r_orow;
    assign o_out_col = r_ocol;
    assign o_last    = r_olast;

`ifndef ASSERT_OFF
    // positions never leave the frame once reset has run
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_row} < r_irows) && (ICOL_W'(r_col) < r_icols))
        else $error("position counter outside frame");

    // the final pixel of a frame wraps both counters
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_pix && cur_last && !cfg_we |=> (r_row == '0) && (r_col == '0))
        else $error("frame did not wrap after last pixel");

    // a bypass is taken only while the same column is being written
    a_fwd_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_pix && r1_v && (r1_cmd == CMD_PIXEL) && (r1_col == cur_col) |-> lb_wr_en)
        else $error("line store bypass without write");

    // upstream is held off only when every stage is occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r1_v && r2_v && r3_v && r_ov)
        else $error("stall with an empty stage");
`endif

endmodule
